/* rtl/tpp_pkg.sv */
package tpp_pkg;

   localparam int VALUE_BITS  = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // divisor, its square, shifted remainder and bit counter widths
   localparam int DIV_W = VALUE_BITS + 1;
   localparam int SQ_W  = 2 * DIV_W;
   localparam int REM_W = VALUE_BITS + 2;
   localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  needs_trial;
   } tpp_entry_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_CHECK,
      BK_DIVIDE,
      BK_DONE
   } tpp_back_state_type;

endpackage

/* rtl/tpp_front.sv */
module tpp_front
   import tpp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_restart,
   input  logic                  queue_full,
   output logic                  push,
   output tpp_entry_type         push_entry
);

   logic [VALUE_BITS-1:0] older_ff, older_in;
   logic [VALUE_BITS-1:0] newer_ff, newer_in;
   logic [1:0]            fill_ff, fill_in;
   logic                  accept;
   logic [1:0]            fill_eff;
   logic                  is_two;
   logic                  odd_candidate;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      fill_eff      = req_restart ? 2'd0 : fill_ff;
      is_two        = (req_value == VALUE_BITS'(2));
      odd_candidate = req_value[0] && (req_value >= VALUE_BITS'(3));

      // only values that can still be prime go on to the back end
      push                   = accept && (fill_eff == 2'd2) && (older_ff[0] ^ newer_ff[0])
                               && (is_two || odd_candidate);
      push_entry.value       = req_value;
      push_entry.needs_trial = !is_two;

      older_in = older_ff;
      newer_in = newer_ff;
      fill_in  = fill_ff;
      if (accept) begin
         older_in = newer_ff;
         newer_in = req_value;
         fill_in  = (fill_eff == 2'd2) ? 2'd2 : fill_eff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff <= '0;
         newer_ff <= '0;
         fill_ff  <= 2'd0;
      end else begin
         older_ff <= older_in;
         newer_ff <= newer_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

/* rtl/tpp_queue.sv */
module tpp_queue
   import tpp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  tpp_entry_type push_entry,
   input  logic          pop,
   output logic          full,
   output logic          not_empty,
   output tpp_entry_type head
);

   tpp_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
         ptr_next = '0;
      end else begin
         ptr_next = p + QPTR_W'(1);
      end
   endfunction

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

/* rtl/tpp_back.sv */
module tpp_back
   import tpp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_not_empty,
   input  tpp_entry_type         queue_head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_prime_value
);

   tpp_back_state_type    state_ff, state_in;
   logic [VALUE_BITS-1:0] num_ff, num_in;
   logic [DIV_W-1:0]      div_ff, div_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_value_ff, rsp_value_in;
   logic [REM_W-1:0]      rem_shift;
   logic [REM_W-1:0]      rem_step;
   logic                  out_free;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_value_ff;
   assign out_free        = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      // one restoring division step per cycle
      rem_shift = {rem_ff[REM_W-2:0], num_ff[cnt_ff]};
      rem_step  = (rem_shift >= REM_W'(div_ff)) ? rem_shift - REM_W'(div_ff) : rem_shift;

      state_in     = state_ff;
      num_in       = num_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;

      case (state_ff)
         BK_IDLE: begin
            if (queue_not_empty) begin
               pop    = 1'b1;
               num_in = queue_head.value;
               div_in = DIV_W'(3);
               sq_in  = SQ_W'(9);
               // the value two needs no divisor
               state_in = queue_head.needs_trial ? BK_CHECK : BK_DONE;
            end
         end
         BK_CHECK: begin
            if (sq_ff > SQ_W'(num_ff)) begin
               state_in = BK_DONE;
            end else begin
               rem_in   = '0;
               cnt_in   = CNT_W'(VALUE_BITS - 1);
               state_in = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            rem_in = rem_step;
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               if (rem_step == '0) begin
                  state_in = BK_IDLE;
               end else begin
                  // (d+2)^2 = d^2 + 4d + 4
                  div_in   = div_ff + DIV_W'(2);
                  sq_in    = sq_ff + SQ_W'({div_ff, 2'b00}) + SQ_W'(4);
                  state_in = BK_CHECK;
               end
            end
         end
         BK_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = num_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff       <= num_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      cnt_ff       <= cnt_in;
      rsp_value_ff <= rsp_value_in;
   end

   a_div_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_CHECK || state_ff == BK_DIVIDE) |-> div_ff[0])
      else $error("trial divisor is even");

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_DIVIDE) |-> (rem_ff < REM_W'(div_ff)))
      else $error("partial remainder not reduced");

   a_result_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff[0] || rsp_value_ff == VALUE_BITS'(2)))
      else $error("result is an even value other than two");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> (state_ff == BK_IDLE))
      else $error("queue read while a trial is running");

endmodule

/* rtl/triplet_parity_prime_filter.sv */
// triplet parity prime filter
// request channel: req_value and req_restart, accepted when req_valid is high
// and req_stall low. a request with req_restart set starts a new list.
// result channel: rsp_prime_value, taken when rsp_valid is high and rsp_stall
// low. a result is given for a request once two earlier list values are held,
// they differ in parity and the request value is prime.
// the front end takes one request per cycle while req_stall is low and drops
// those that cannot pass; candidates go through a two-entry queue to the
// trial division engine. the engine tests odd divisors from 3 while the
// divisor squared stays at or below the value, each with a square check and
// a bit-serial remainder, one bit per cycle. the value two goes to the result
// without a trial divisor.
// after reset the window is empty, the queue is empty and rsp_valid is low.
// while rsp_stall is high the result is held, the engine waits with its next
// result, the queue fills and then req_stall goes high.
module triplet_parity_prime_filter
   import tpp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_restart,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VALUE_BITS-1:0] rsp_prime_value
);

   logic          push;
   tpp_entry_type push_entry;
   logic          pop;
   logic          queue_full;
   logic          queue_not_empty;
   tpp_entry_type queue_head;

   tpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_value  (req_value),
      .req_restart(req_restart),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   tpp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (queue_head)
   );

   tpp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .queue_not_empty(queue_not_empty),
      .queue_head     (queue_head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_value(rsp_prime_value)
   );

endmodule

/* tb/triplet_parity_prime_filter_tb.sv */
`timescale 1ns / 100ps

module triplet_parity_prime_filter_tb;
   import tpp_pkg::*;

   localparam int DIRECTED_COUNT = 24;
   localparam int RANDOM_PER_PHASE = 609;
   localparam int PHASE_COUNT = 3;
   localparam int DRAIN_CYCLES = 200;
   localparam int REPORT_LIMIT = 10;

   localparam int unsigned SEND_PCTS [PHASE_COUNT] = '{26, 52, 0};
   localparam int unsigned RECV_PCTS [PHASE_COUNT] = '{52, 26, 0};

   // one directed request; typed rows carry their expected result
   typedef struct packed {
      logic [VALUE_BITS-1:0] value;
      logic                  restart;
      logic                  typed;
      logic                  hit;
      logic [VALUE_BITS-1:0] result;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{10'd1023, 1'b0, 1'b1, 1'b0, 10'd0},     // empty window
      '{10'd0,    1'b0, 1'b1, 1'b0, 10'd0},     // one value held
      '{10'd2,    1'b0, 1'b1, 1'b1, 10'd2},     // smallest prime
      '{10'd3,    1'b0, 1'b1, 1'b0, 10'd0},     // both earlier even
      '{10'd1021, 1'b0, 1'b1, 1'b1, 10'd1021},  // largest prime
      '{10'd7,    1'b0, 1'b1, 1'b0, 10'd0},     // both earlier odd
      '{10'd4,    1'b0, 1'b1, 1'b0, 10'd0},
      '{10'd1,    1'b0, 1'b1, 1'b0, 10'd0},     // one is not prime
      '{10'd0,    1'b0, 1'b1, 1'b0, 10'd0},     // zero is not prime
      '{10'd961,  1'b0, 1'b0, 1'b0, 10'd0},     // square of the largest divisor
      '{10'd1019, 1'b0, 1'b0, 1'b0, 10'd0},
      '{10'd9,    1'b0, 1'b0, 1'b0, 10'd0},
      '{10'd2,    1'b1, 1'b1, 1'b0, 10'd0},     // restart clears the window
      '{10'd5,    1'b0, 1'b1, 1'b0, 10'd0},
      '{10'd3,    1'b0, 1'b1, 1'b1, 10'd3},
      '{10'd7,    1'b1, 1'b1, 1'b0, 10'd0},     // back to back restarts
      '{10'd8,    1'b1, 1'b1, 1'b0, 10'd0},
      '{10'd3,    1'b0, 1'b1, 1'b0, 10'd0},
      '{10'd11,   1'b0, 1'b1, 1'b1, 10'd11},
      '{10'd1022, 1'b0, 1'b0, 1'b0, 10'd0},
      '{10'd25,   1'b0, 1'b0, 1'b0, 10'd0},
      '{10'd49,   1'b0, 1'b0, 1'b0, 10'd0},
      '{10'd1023, 1'b0, 1'b0, 1'b0, 10'd0},
      '{10'd997,  1'b1, 1'b0, 1'b0, 10'd0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  req_restart = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VALUE_BITS-1:0] rsp_prime_value;

   int unsigned send_idle_pct = 26;
   int unsigned recv_idle_pct = 52;
   int unsigned mismatches = 0;

   // window copy kept alongside the block
   logic [VALUE_BITS-1:0] older_value = '0;
   logic [VALUE_BITS-1:0] newer_value = '0;
   logic [1:0]            window_fill = '0;

   logic [VALUE_BITS-1:0] expected_primes [$];

   triplet_parity_prime_filter DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_value (rsp_prime_value)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic bit prime_by_trial(input logic [VALUE_BITS-1:0] n);
      int unsigned divisor;
      if (n <= 1) return 1'b0;
      if (n == 2) return 1'b1;
      if (!n[0]) return 1'b0;
      for (divisor = 3; divisor * divisor <= n; divisor += 2)
         if (n % divisor == 0) return 1'b0;
      return 1'b1;
   endfunction

   // advances the window and tells whether the value passes the filter
   function automatic bit filter_step(input logic [VALUE_BITS-1:0] value,
                                      input logic restart,
                                      output logic [VALUE_BITS-1:0] passed);
      bit hit;
      hit = 1'b0;
      passed = '0;
      if (restart) window_fill = '0;
      if (window_fill >= 2 && (older_value[0] ^ newer_value[0]) && prime_by_trial(value)) begin
         hit = 1'b1;
         passed = value;
      end
      older_value = newer_value;
      newer_value = value;
      if (window_fill < 2) window_fill = window_fill + 1'b1;
      return hit;
   endfunction

   function automatic void log_mismatch(input string what, input logic [VALUE_BITS-1:0] want,
                                        input logic [VALUE_BITS-1:0] got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("mismatch at %0t: %s, expected %0d, got %0d", $time, what, want, got);
   endfunction

   task automatic send_request(input logic [VALUE_BITS-1:0] value, input logic restart,
                               input logic typed, input logic hit,
                               input logic [VALUE_BITS-1:0] result);
      logic [VALUE_BITS-1:0] passed;
      bit                    predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= value;
      req_restart <= restart;
      do @(posedge clock); while (req_stall);
      predicted = filter_step(value, restart, passed);
      if (typed) begin
         predicted = hit;
         passed = result;
      end
      if (predicted) expected_primes = {expected_primes, passed};
   endtask

   // result side: random stall and check against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_primes.size() == 0)
               log_mismatch("result with none expected", '0, rsp_prime_value);
            else if (expected_primes[0] !== rsp_prime_value)
               log_mismatch("prime_value", expected_primes.pop_front(), rsp_prime_value);
            else
               void'(expected_primes.pop_front());
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      logic [VALUE_BITS-1:0] value;
      logic                  restart;
      int unsigned           pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_request(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].restart,
                      DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].hit, DIRECTED_ROWS[i].result);

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct = SEND_PCTS[phase];
         recv_idle_pct = RECV_PCTS[phase];
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
               case ($urandom_range(5))
                  0: value = 10'd0;
                  1: value = 10'd1;
                  2: value = 10'd2;
                  3: value = 10'd1021;
                  4: value = 10'd1022;
                  default: value = 10'd1023;
               endcase
            end else if (pick < 30) begin
               value = VALUE_BITS'($urandom_range(40));
            end else if (pick < 65) begin
               // odd values keep prime candidates frequent
               value = VALUE_BITS'($urandom) | 1'b1;
            end else begin
               value = VALUE_BITS'($urandom);
            end
            restart = ($urandom_range(99) < 4);
            send_request(value, restart, 1'b0, 1'b0, '0);
         end
      end
      req_valid <= 1'b0;

      while (expected_primes.size() != 0) @(posedge clock);
      // composite candidates may still be in the divider
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_primes.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
